FILE: sv/modbus_rtu_register_slave_unit_defines.svh
// assertion macros used by the property file
`ifndef MODBUS_RTU_REGISTER_SLAVE_UNIT_DEFINES_SVH
`define MODBUS_RTU_REGISTER_SLAVE_UNIT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define MBRS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define MBRS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/mbrs_pkg.sv
// shared types, constants and crc function of the modbus rtu slave
package mbrs_pkg;

    localparam int REG_COUNT = 16;
    localparam int FRAME_LEN = 8;
    localparam int FCNT_W    = 3;
    localparam int IDX_W     = 6;

    localparam logic [15:0] CRC_INIT        = 16'hFFFF;
    localparam logic [15:0] CRC_POLY        = 16'hA001;
    localparam logic [7:0]  FN_READ_HOLD    = 8'h03;
    localparam logic [7:0]  FN_WRITE_SINGLE = 8'h06;
    localparam logic [7:0]  SLAVE_ADDR_RST  = 8'h01;

    typedef struct packed {
        logic        op;
        logic [7:0]  rx_byte;
        logic        starts_frame;
        logic [3:0]  reg_index;
        logic [15:0] reg_value;
    } req_t;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       last;
    } rsp_t;

    typedef struct packed {
        logic begin_check;
        logic crc_rx_step;
        logic start_reply;
        logic exec_write;
        logic send_msg;
        logic send_crc_lo;
        logic send_crc_hi;
    } cmd_t;

    typedef struct packed {
        logic frame_full;
        logic crc_last;
        logic read_ok;
        logic write_ok;
        logic msg_done;
        logic out_free;
    } status_t;

    // one byte of crc-16/modbus, lsb first
    function automatic logic [15:0] crc16_update(input logic [15:0] crc_in,
                                                 input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

FILE: sv/modbus_rtu_register_slave_unit.sv
// top level of the modbus rtu register slave
//
//   port group   dir  handshake              payload
//   req          in   req_valid / req_stall  req_t: op, rx_byte, starts_frame, reg_index, reg_value
//   rsp          out  rsp_valid / rsp_stall  rsp_t: tx_byte, last
//   cfg          in   cfg_we                 cfg_wdata: slave address
//
// a serial byte or local write beat is taken only while the sequencer is idle
// the eighth byte of a frame starts a byte-wide crc over the first six bytes, then a check step
// a reply then goes out one byte per cycle while rsp_stall allows, n + 2 bytes (8 for a write, up to 37 for a read)
// req_stall is high after the frame-completing beat until the last reply byte is loaded or the frame fails its check
// rsp_stall holds the output register and the reply sequencer; reset clears the holding registers at once
module modbus_rtu_register_slave_unit
    import mbrs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_stall,
    input  req_t       req,
    output logic       rsp_valid,
    input  logic       rsp_stall,
    output rsp_t       rsp,
    input  logic       cfg_we,
    input  logic [7:0] cfg_wdata
);

    logic    req_take;
    cmd_t    cmd;
    status_t status;

    assign req_take = req_valid && !req_stall;

    mbrs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_take  (req_take),
        .status    (status),
        .req_stall (req_stall),
        .cmd       (cmd)
    );

    mbrs_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .req_take  (req_take),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .rsp_stall (rsp_stall),
        .cmd       (cmd),
        .status    (status),
        .rsp_valid (rsp_valid),
        .rsp       (rsp)
    );

endmodule

FILE: sv/mbrs_datapath.sv
// frame buffer, holding registers, crc and response register
module mbrs_datapath
    import mbrs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  req_t        req,
    input  logic        req_take,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,
    input  logic        rsp_stall,
    input  cmd_t        cmd,
    output status_t     status,
    output logic        rsp_valid,
    output rsp_t        rsp
);

    logic [7:0]        fb_reg [FRAME_LEN];
    logic [15:0]       hr_reg [REG_COUNT];
    logic [FCNT_W-1:0] cnt_reg;
    logic [FCNT_W-1:0] cnt_base;
    logic [FCNT_W-1:0] cnt_next;
    logic [7:0]        slave_addr_reg;
    logic [15:0]       crc_reg;
    logic [15:0]       crc_next;
    logic [IDX_W-1:0]  idx_reg;
    logic              mode_read_reg;
    logic              rsp_valid_reg;
    rsp_t              rsp_reg;

    logic [15:0]      first_w;
    logic [15:0]      count_w;
    logic [16:0]      end_w;
    logic             crc_ok;
    logic             addr_ok;
    logic [IDX_W-1:0] msg_len;
    logic [IDX_W-1:0] rel_idx;
    logic [4:0]       rd_sum;
    logic [15:0]      rd_word;
    logic [7:0]       msg_byte;
    logic             local_ok;

    assign cnt_base = req.starts_frame ? '0 : cnt_reg;
    assign cnt_next = (cnt_base == FCNT_W'(FRAME_LEN - 1)) ? '0 : cnt_base + 1'b1;
    assign local_ok = {1'b0, req.reg_index} < 5'(REG_COUNT);

    assign first_w = {fb_reg[2], fb_reg[3]};
    assign count_w = {fb_reg[4], fb_reg[5]};
    assign end_w   = {1'b0, first_w} + {1'b0, count_w};
    assign crc_ok  = crc_reg == {fb_reg[7], fb_reg[6]};
    assign addr_ok = fb_reg[0] == slave_addr_reg;

    // read reply: address, function, byte count, then register words
    assign msg_len = mode_read_reg ? (IDX_W'(3) + {count_w[4:0], 1'b0}) : IDX_W'(6);
    assign rel_idx = idx_reg - IDX_W'(3);
    assign rd_sum  = 5'(first_w[3:0]) + 5'(rel_idx[IDX_W-1:1]);
    assign rd_word = hr_reg[rd_sum[3:0]];

    always_comb
    begin
        if (mode_read_reg)
        begin
            case (idx_reg)
                IDX_W'(0): msg_byte = fb_reg[0];
                IDX_W'(1): msg_byte = FN_READ_HOLD;
                IDX_W'(2): msg_byte = {count_w[6:0], 1'b0};
                default:   msg_byte = rel_idx[0] ? rd_word[7:0] : rd_word[15:8];
            endcase
        end
        else
        begin
            msg_byte = fb_reg[idx_reg[2:0]];
        end
    end

    always_comb
    begin
        crc_next = crc_reg;
        if (cmd.begin_check || cmd.start_reply)
            crc_next = CRC_INIT;
        else if (cmd.crc_rx_step)
            crc_next = crc16_update(crc_reg, fb_reg[idx_reg[2:0]]);
        else if (cmd.send_msg)
            crc_next = crc16_update(crc_reg, msg_byte);
    end

    always_comb
    begin
        status.frame_full = !req.op && (cnt_base == FCNT_W'(FRAME_LEN - 1));
        status.crc_last   = idx_reg == IDX_W'(5);
        status.read_ok    = crc_ok && addr_ok && (fb_reg[1] == FN_READ_HOLD)
                            && (count_w != 16'd0) && (end_w <= 17'(REG_COUNT));
        status.write_ok   = crc_ok && addr_ok && (fb_reg[1] == FN_WRITE_SINGLE)
                            && (first_w < 16'(REG_COUNT));
        status.msg_done   = idx_reg == msg_len;
        status.out_free   = !rsp_valid_reg || !rsp_stall;
    end

    // frame bytes need no reset, each is written before it is read
    always_ff @(posedge clk)
    begin
        if (req_take && !req.op)
            fb_reg[cnt_base] <= req.rx_byte;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < REG_COUNT; i++)
                hr_reg[i] <= '0;
        end
        else if (req_take && req.op && local_ok)
        begin
            hr_reg[req.reg_index] <= req.reg_value;
        end
        else if (cmd.exec_write)
        begin
            hr_reg[first_w[3:0]] <= count_w;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg        <= '0;
            slave_addr_reg <= SLAVE_ADDR_RST;
            crc_reg        <= CRC_INIT;
            idx_reg        <= '0;
            mode_read_reg  <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            if (req_take && !req.op)
                cnt_reg <= cnt_next;
            if (cfg_we)
                slave_addr_reg <= cfg_wdata;
            crc_reg <= crc_next;
            if (cmd.begin_check || cmd.start_reply)
                idx_reg <= '0;
            else if (cmd.crc_rx_step || cmd.send_msg)
                idx_reg <= idx_reg + 1'b1;
            if (cmd.start_reply)
                mode_read_reg <= status.read_ok;
            if (cmd.send_msg || cmd.send_crc_lo || cmd.send_crc_hi)
                rsp_valid_reg <= 1'b1;
            else if (!rsp_stall)
                rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.send_msg)
            rsp_reg <= '{tx_byte: msg_byte, last: 1'b0};
        else if (cmd.send_crc_lo)
            rsp_reg <= '{tx_byte: crc_reg[7:0], last: 1'b0};
        else if (cmd.send_crc_hi)
            rsp_reg <= '{tx_byte: crc_reg[15:8], last: 1'b1};
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

FILE: sv/mbrs_ctrl.sv
// sequencer for frame check and reply emission
module mbrs_ctrl
    import mbrs_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    req_take,
    input  status_t status,
    output logic    req_stall,
    output cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CRC,
        S_CHECK,
        S_SEND,
        S_CRC_HI
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_take && status.frame_full)
                begin
                    cmd.begin_check = 1'b1;
                    state_next      = S_CRC;
                end
            end
            S_CRC:
            begin
                cmd.crc_rx_step = 1'b1;
                if (status.crc_last)
                    state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (status.read_ok || status.write_ok)
                begin
                    cmd.start_reply = 1'b1;
                    cmd.exec_write  = status.write_ok;
                    state_next      = S_SEND;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_SEND:
            begin
                if (status.out_free)
                begin
                    if (status.msg_done)
                    begin
                        cmd.send_crc_lo = 1'b1;
                        state_next      = S_CRC_HI;
                    end
                    else
                    begin
                        cmd.send_msg = 1'b1;
                    end
                end
            end
            S_CRC_HI:
            begin
                if (status.out_free)
                begin
                    cmd.send_crc_hi = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign req_stall = state_reg != S_IDLE;

endmodule

FILE: sv/mbrs_props.sv
// port-level properties of the slave, bound to the top level
`include "modbus_rtu_register_slave_unit_defines.svh"

module mbrs_props
    import mbrs_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_stall,
    input req_t req,
    input logic rsp_valid,
    input logic rsp_stall,
    input rsp_t rsp
);

    // a held response beat keeps its value
    `MBRS_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp), "response beat changed while stalled")

    // mid-reply bytes only appear while the request side is held off
    `MBRS_ASSERT_NOW(a_reply_busy, rsp_valid && !rsp.last, req_stall, "request accepted during a reply")

    // a local write never starts frame processing
    `MBRS_ASSERT_NEXT(a_local_idle, req_valid && !req_stall && req.op, !req_stall, "local write made the slave busy")

    // a gap-marked byte is byte zero and cannot complete a frame
    `MBRS_ASSERT_NEXT(a_gap_idle, req_valid && !req_stall && !req.op && req.starts_frame, !req_stall, "frame restart made the slave busy")

endmodule

bind modbus_rtu_register_slave_unit mbrs_props u_props (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);
